// ===== rtl/flpw_pkg.sv =====
// Shared types and constants of the four-level page table walk.
package flpw_pkg;

    localparam int TABLE_WORDS = 4096;
    localparam int STORE_AW    = $clog2(TABLE_WORDS);

    localparam int FRAME_W  = 40;
    localparam int VA_W     = 48;
    localparam int PA_W     = 52;
    localparam int IDX_W    = 9;
    localparam int OFF_W    = 12;
    localparam int WORD_W   = FRAME_W + IDX_W;
    localparam int DATA_W   = 64;
    localparam int WIDX_W   = 12;
    localparam int LVL_W    = 2;
    localparam int FRAME_LO = OFF_W;
    localparam int FRAME_HI = OFF_W + FRAME_W - 1;

    localparam logic [LVL_W-1:0]    LVL_TOP   = 2'd0;
    localparam logic [LVL_W-1:0]    LVL_LAST  = 2'd3;
    localparam logic [WORD_W-1:0]   WORD_LIMIT = WORD_W'(TABLE_WORDS);
    localparam logic [STORE_AW-1:0] CLR_LAST  = STORE_AW'(TABLE_WORDS - 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_OUTSIDE     = 2'd2
    } t_status;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_WALK  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_DATA,
        S_RESP
    } t_walk_state;

    typedef struct packed {
        t_kind              kind;
        logic [WIDX_W-1:0]  word_index;
        logic [DATA_W-1:0]  word_data;
        logic [VA_W-1:0]    virtual_address;
    } t_item;

    typedef struct packed {
        logic               valid;
        t_status            status;
        logic [PA_W-1:0]    physical_address;
        logic [LVL_W-1:0]   fault_level;
    } t_result;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== rtl/flpw_store.sv =====
// Table word store: one write port, one read port with registered read data.
module flpw_store (
    input  logic                     i_clk,
    input  flpw_pkg::t_mem_req       i_req,
    output logic [flpw_pkg::DATA_W-1:0] o_rdata
);
    import flpw_pkg::*;

    logic [DATA_W-1:0] r_mem [TABLE_WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/flpw_walker.sv =====
// Walk sequencer: store clearing, table writes and the four-level fetch loop.
module flpw_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  flpw_pkg::t_item               i_item,
    output logic                          o_item_ready,
    input  logic [flpw_pkg::FRAME_W-1:0]  i_root_frame,
    output flpw_pkg::t_result             o_res,
    input  logic                          i_res_ready,
    output flpw_pkg::t_mem_req            o_mem,
    input  logic [flpw_pkg::DATA_W-1:0]   i_rdata
);
    import flpw_pkg::*;

    t_walk_state         r_state, n_state;
    logic [LVL_W-1:0]    r_level, n_level;
    logic [STORE_AW-1:0] r_clr, n_clr;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [VA_W-1:0]     r_va, n_va;
    t_status             r_status, n_status;
    logic [PA_W-1:0]     r_pa, n_pa;
    logic [LVL_W-1:0]    r_flevel, n_flevel;

    logic                accept;
    logic [IDX_W-1:0]    lvl_idx;
    logic [WORD_W-1:0]   fetch_word;
    logic                fetch_outside;
    logic                entry_present;
    logic [WORD_W-1:0]   wr_word;
    logic                wr_inside;

    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;

    // index bits of the current level: 47..39, 38..30, 29..21, 20..12
    always_comb begin
        unique case (r_level)
            2'd0:    lvl_idx = r_va[OFF_W+3*IDX_W +: IDX_W];
            2'd1:    lvl_idx = r_va[OFF_W+2*IDX_W +: IDX_W];
            2'd2:    lvl_idx = r_va[OFF_W+IDX_W +: IDX_W];
            default: lvl_idx = r_va[OFF_W +: IDX_W];
        endcase
    end

    assign fetch_word    = {r_frame, lvl_idx};
    assign fetch_outside = (fetch_word >= WORD_LIMIT);
    assign entry_present = i_rdata[0];
    assign wr_word       = WORD_W'(i_item.word_index);
    assign wr_inside     = (wr_word < WORD_LIMIT);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_item.kind == KIND_WRITE) ? S_RESP : S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = fetch_outside ? S_RESP : S_DATA;
            end
            S_DATA: begin
                if (!entry_present || r_level == LVL_LAST) n_state = S_RESP;
                else n_state = S_ADDR;
            end
            S_RESP: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and store requests
    always_comb begin
        n_level  = r_level;
        n_clr    = r_clr;
        n_frame  = r_frame;
        n_va     = r_va;
        n_status = r_status;
        n_pa     = r_pa;
        n_flevel = r_flevel;
        o_mem    = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                o_mem.wdata = '0;
                n_clr       = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.kind == KIND_WRITE) begin
                        o_mem.we    = wr_inside;
                        o_mem.waddr = wr_word[STORE_AW-1:0];
                        o_mem.wdata = i_item.word_data;
                        n_status    = ST_OK;
                        n_pa        = '0;
                        n_flevel    = '0;
                    end else begin
                        n_frame = i_root_frame;
                        n_va    = i_item.virtual_address;
                        n_level = LVL_TOP;
                    end
                end
            end
            S_ADDR: begin
                if (fetch_outside) begin
                    n_status = ST_OUTSIDE;
                    n_pa     = '0;
                    n_flevel = r_level;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = fetch_word[STORE_AW-1:0];
                end
            end
            S_DATA: begin
                if (!entry_present) begin
                    n_status = ST_NOT_PRESENT;
                    n_pa     = '0;
                    n_flevel = r_level;
                end else begin
                    n_frame = i_rdata[FRAME_HI:FRAME_LO];
                    if (r_level == LVL_LAST) begin
                        n_status = ST_OK;
                        n_pa     = {i_rdata[FRAME_HI:FRAME_LO], r_va[OFF_W-1:0]};
                        n_flevel = '0;
                    end else begin
                        n_level = r_level + 1'b1;
                    end
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_level <= LVL_TOP;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame  <= n_frame;
        r_va     <= n_va;
        r_status <= n_status;
        r_pa     <= n_pa;
        r_flevel <= n_flevel;
    end

    assign o_res.valid            = (r_state == S_RESP);
    assign o_res.status           = r_status;
    assign o_res.physical_address = r_pa;
    assign o_res.fault_level      = r_flevel;

endmodule

// ===== rtl/four_level_page_table_walk.sv =====
// Top level of the four-level page table walk: ports, root register, result register.
//
// Slave stream s_*: one item per transfer. s_tuser is the kind (0 write a
// table word, 1 translate). A write stores word_data at word_index of the
// internal 4096-word table store; a translate walks four tables of 512
// entries starting at the root frame and returns the physical address.
// Master stream m_*: one result per item, in order; m_tuser is the status
// (0 ok, 1 entry not present, 2 fetch outside the store).
// The root frame register is loaded by i_cfg_we / i_cfg_wdata at any edge while i_rst_n is high.
// Walk: per level the sequencer forms the fetch address and issues the read in
// S_ADDR, then takes the registered read data of the store's single read port
// in S_DATA; faults end the walk early.
// Items are handled one at a time; s_tready is high only while the sequencer
// is idle, and a finished result waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// sequencer holds its next result, so s_tready stays low after one more item.
// Reset: synchronous, active low. The root frame clears to 0 and the store is
// swept to zero, one word per cycle over all 4096 words, during which s_tready is
// low; configuration writes are taken throughout.
module four_level_page_table_walk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [39:0]   i_cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // word_index[11:0], word_data[75:12], virtual_address[123:76]
    input  logic          s_tuser,   // kind[0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,   // physical_address[51:0], fault_level[53:52]
    output logic [1:0]    m_tuser    // status[1:0]
);
    import flpw_pkg::*;

    logic [FRAME_W-1:0] r_root;
    t_item              item;
    t_result            res;
    logic               res_ready;
    t_mem_req           mem_req;
    logic [DATA_W-1:0]  rdata;

    logic               r_m_valid;
    t_status            r_m_status;
    logic [PA_W-1:0]    r_m_pa;
    logic [LVL_W-1:0]   r_m_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    assign item.kind            = t_kind'(s_tuser);
    assign item.word_index      = s_tdata[WIDX_W-1:0];
    assign item.word_data       = s_tdata[WIDX_W +: DATA_W];
    assign item.virtual_address = s_tdata[WIDX_W+DATA_W +: VA_W];

    flpw_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_tvalid),
        .i_item       (item),
        .o_item_ready (s_tready),
        .i_root_frame (r_root),
        .o_res        (res),
        .i_res_ready  (res_ready),
        .o_mem        (mem_req),
        .i_rdata      (rdata)
    );

    flpw_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // load the result register when it is empty or being drained
    assign res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_m_status <= res.status;
            r_m_pa     <= res.physical_address;
            r_m_level  <= res.fault_level;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {2'b00, r_m_level, r_m_pa};
    assign m_tuser  = r_m_status;

endmodule

// ===== tb/four_level_page_table_walk_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the four-level page table walk: directed walks, then random mappings.
module four_level_page_table_walk_test;
    import flpw_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_COUNT    = 6;
    localparam logic [VA_W-1:0] VA_TOP = {VA_W{1'b1}};

    typedef struct {
        t_status          status;
        logic [PA_W-1:0]  phys_addr;
        logic [LVL_W-1:0] level;
    } t_walk_outcome;

    class t_walk_scoreboard;
        logic [DATA_W-1:0]  table_words [TABLE_WORDS];
        logic [FRAME_W-1:0] root_frame;
        t_walk_outcome      pending_results[$];
        int mismatches;
        int writes_seen;
        int walks_mapped;
        int walks_not_present;
        int walks_outside;

        function new();
            foreach (table_words[i]) table_words[i] = '0;
            root_frame        = '0;
            mismatches        = 0;
            writes_seen       = 0;
            walks_mapped      = 0;
            walks_not_present = 0;
            walks_outside     = 0;
        endfunction

        function t_walk_outcome walk_translate(logic [VA_W-1:0] va);
            t_walk_outcome      r;
            logic [FRAME_W-1:0] frame;
            logic [DATA_W-1:0]  entry;
            logic [WORD_W-1:0]  word;
            r.status    = ST_OK;
            r.phys_addr = '0;
            r.level     = '0;
            frame       = root_frame;
            entry       = '0;
            for (int lv = 0; lv < 4; lv++) begin
                word = {frame, va[OFF_W + IDX_W * (3 - lv) +: IDX_W]};
                if (word >= WORD_LIMIT) begin
                    r.status = ST_OUTSIDE;
                    r.level  = LVL_W'(lv);
                    return r;
                end
                entry = table_words[word[STORE_AW-1:0]];
                if (!entry[0]) begin
                    r.status = ST_NOT_PRESENT;
                    r.level  = LVL_W'(lv);
                    return r;
                end
                frame = entry[FRAME_HI:FRAME_LO];
            end
            r.phys_addr = {entry[FRAME_HI:FRAME_LO], va[OFF_W-1:0]};
            return r;
        endfunction

        function void note_item(t_kind kind, logic [WIDX_W-1:0] widx,
                                logic [DATA_W-1:0] wdata, logic [VA_W-1:0] va);
            t_walk_outcome r;
            if (kind == KIND_WRITE) begin
                if (int'(widx) < TABLE_WORDS) table_words[widx] = wdata;
                r.status    = ST_OK;
                r.phys_addr = '0;
                r.level     = '0;
                writes_seen++;
            end else begin
                r = walk_translate(va);
                case (r.status)
                    ST_OK:          walks_mapped++;
                    ST_NOT_PRESENT: walks_not_present++;
                    default:        walks_outside++;
                endcase
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [PA_W-1:0] pa,
                                   logic [LVL_W-1:0] lvl);
            t_walk_outcome exp_r;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing pending: status %0d addr %h level %0d",
                         $time, status, pa, lvl);
                return;
            end
            exp_r = pending_results.pop_front();
            if (status !== exp_r.status || pa !== exp_r.phys_addr || lvl !== exp_r.level) begin
                mismatches++;
                $display("%0t: mismatch expected status %0d addr %h level %0d", $time,
                         exp_r.status, exp_r.phys_addr, exp_r.level);
                $display("%0t:            actual status %0d addr %h level %0d", $time,
                         status, pa, lvl);
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [FRAME_W-1:0]  i_cfg_wdata = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [127:0]        s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [55:0]         m_tdata;
    logic [1:0]          m_tuser;

    t_walk_scoreboard sb = new();
    int items_sent   = 0;
    int root_writes  = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    bit steady       = 1'b0;

    four_level_page_table_walk u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Entry with random attribute bits around the frame field.
    function automatic logic [DATA_W-1:0] make_entry(logic present, logic [FRAME_W-1:0] frame);
        logic [63:0] attr;
        attr = rand_word();
        return {attr[63:52], frame, attr[11:1], present};
    endfunction

    // Favor a few hot indices so that random walks hit written entries.
    function automatic logic [IDX_W-1:0] pick_table_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return '0;
        if (roll < 55) return {IDX_W{1'b1}};
        if (roll < 70) return IDX_W'(1);
        return IDX_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [VA_W-1:0] make_va();
        if ($urandom_range(0, 4) == 0) return VA_W'(rand_word());
        return {pick_table_index(), pick_table_index(), pick_table_index(),
                pick_table_index(), OFF_W'($urandom)};
    endfunction

    // Receiver side: random stalls of mixed length; no new stall starts while steady.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_item(t_kind'(s_tuser), s_tdata[11:0], s_tdata[75:12], s_tdata[123:76]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[51:0], m_tdata[53:52]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold the sender off until every pending result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_root(logic [FRAME_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.root_frame = value;
        root_writes++;
    endtask

    task automatic send_item(t_kind kind, logic [WIDX_W-1:0] widx,
                             logic [DATA_W-1:0] wdata, logic [VA_W-1:0] va);
        int gap;
        bit hold;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, va, wdata, widx};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        gap  = (!steady && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        hold = ($urandom_range(0, 249) == 0);
        if (hold) begin
            wait_for_results();
        end else if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_write(logic [WIDX_W-1:0] widx, logic [DATA_W-1:0] wdata);
        send_item(KIND_WRITE, widx, wdata, VA_W'(rand_word()));
    endtask

    task automatic send_walk(logic [VA_W-1:0] va);
        send_item(KIND_WALK, WIDX_W'($urandom), rand_word(), va);
    endtask

    // Write the four entries that map va from the low three bits of the current root
    // frame, sometimes breaking one level, then translate it.
    task automatic build_mapping(logic [VA_W-1:0] va);
        logic [FRAME_W-1:0] cur;
        logic [FRAME_W-1:0] nxt;
        logic               present;
        int                 broken;
        broken = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 3) : -1;
        cur    = sb.root_frame;
        for (int lv = 0; lv < 4; lv++) begin
            nxt     = (lv == 3) ? FRAME_W'(rand_word()) : FRAME_W'($urandom_range(0, 7));
            present = 1'b1;
            if (lv == broken) begin
                if ($urandom_range(0, 1) == 1) present = 1'b0;
                else nxt = FRAME_W'(rand_word());
            end
            send_write({cur[2:0], va[OFF_W + IDX_W * (3 - lv) +: IDX_W]},
                       make_entry(present, nxt));
            cur = nxt;
        end
        send_walk(va);
        if ($urandom_range(0, 1) == 1) send_walk({va[VA_W-1:OFF_W], OFF_W'($urandom)});
    endtask

    initial begin
        int                 phase_end;
        int                 roll;
        logic [FRAME_W-1:0] root;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_root('0);

        // Empty store, then walk the all-ones address one level deeper each time.
        send_walk('0);
        send_write(WIDX_W'(4095), {DATA_W{1'b1}});
        send_write(WIDX_W'(511), {12'hfff, 40'd7, 12'hfff});
        send_walk(VA_TOP);
        send_write(WIDX_W'(4095), {12'h000, 40'd6, 12'h001});
        send_walk(VA_TOP);
        send_write(WIDX_W'(3583), {12'habc, 40'd5, 12'h081});
        send_walk(VA_TOP);
        send_write(WIDX_W'(3071), {DATA_W{1'b1}});
        send_walk(VA_TOP);
        send_walk({36'hfff_ffff_ff, 12'h000});
        send_write(WIDX_W'(3583), {12'h000, 40'd9, 12'h001});
        send_walk(VA_TOP);
        send_write('0, {12'h000, 40'd8, 12'h001});
        send_walk('0);
        send_write('0, {12'h000, 40'd1, 12'h001});
        send_walk('0);
        send_write('0, '0);
        send_walk('0);
        // Root frame just past the store, then the largest root frame.
        wait_for_results();
        write_root(FRAME_W'(8));
        send_walk('0);
        wait_for_results();
        write_root({FRAME_W{1'b1}});
        send_walk(VA_TOP);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       root = '0;
                1:       root = FRAME_W'(7);
                4:       root = FRAME_W'(rand_word());
                default: root = FRAME_W'($urandom_range(0, 7));
            endcase
            wait_for_results();
            write_root(root);
            phase_end = items_sent + ((p == 4) ? 40 : 290);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 19) == 0) steady = !steady;
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    build_mapping(make_va());
                else if (roll < 70)
                    send_walk(make_va());
                else if (roll < 85)
                    send_write({3'($urandom_range(0, 7)), pick_table_index()},
                               make_entry($urandom_range(0, 9) != 0,
                                          FRAME_W'($urandom_range(0, 9))));
                else
                    send_write(WIDX_W'($urandom), rand_word());
            end
            steady = 1'b0;
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
        end

        $display("Covered %0d table writes and %0d translations under %0d root frame settings.",
                 sb.writes_seen, sb.walks_mapped + sb.walks_not_present + sb.walks_outside,
                 root_writes);
        $display("Translations: %0d mapped, %0d not present, %0d outside the store; %0d errors.",
                 sb.walks_mapped, sb.walks_not_present, sb.walks_outside, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/flpw_pkg.sv
rtl/flpw_store.sv
rtl/flpw_walker.sv
rtl/four_level_page_table_walk.sv
tb/four_level_page_table_walk_test.sv
